// ----- hdl/hln_pkg.sv -----
package hln_pkg;

  localparam int VAL_W = 20;
  localparam int TAN_W = 16;
  localparam int NOISE_W = 17;
  localparam int NOISE_MAX = 65536;

  localparam logic [1:0] OP_EVAL = 2'd0;
  localparam logic [1:0] OP_PERM = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [3:0] MOP_TT   = 4'd0;
  localparam logic [3:0] MOP_T2T  = 4'd1;
  localparam logic [3:0] MOP_V0   = 4'd2;
  localparam logic [3:0] MOP_V1   = 4'd3;
  localparam logic [3:0] MOP_T0   = 4'd4;
  localparam logic [3:0] MOP_T1   = 4'd5;
  localparam logic [3:0] MOP_GX   = 4'd6;
  localparam logic [3:0] MOP_GY   = 4'd7;
  localparam logic [3:0] MOP_GZ   = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AX,
    S_AXW,
    S_RD1,
    S_MOD1,
    S_MW1,
    S_RD2,
    S_MOD2,
    S_MW2,
    S_RD3,
    S_LD,
    S_MERGE,
    S_POST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [2:0][TAN_W-1:0] tan;
  } node_t;

endpackage

// ----- hdl/hln_mod.sv -----
module hln_mod #(
  parameter int N = 256,
  parameter int MW = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [MW-1:0] value,
  output logic done,
  output logic [$clog2(N)-1:0] rem
);

  localparam int AB = $clog2(N);
  localparam bit POW2 = ((1 << AB) == N);

  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          rem <= value[AB-1:0];
        end
      end
    end else begin : g_recip
      // quotient by reciprocal multiplication, exact for every MW-bit value
      localparam int SH = MW + AB;
      localparam longint unsigned MINV_L = ((64'd1 << SH) + 64'(N) - 64'd1) / 64'(N);
      localparam logic [MW:0] MINV = (MW+1)'(MINV_L);
      localparam logic [MW-1:0] NK = MW'(N);
      logic [1:0] stage;
      logic [MW-1:0] vreg;
      logic [2*MW:0] prod;
      logic [MW-1:0] quot;

      assign quot = MW'(prod[2*MW:SH]);

      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
          done <= 1'b0;
        end else begin
          stage <= {stage[0], start};
          done <= stage[1];
        end
        if (start) begin
          vreg <= value;
        end
        if (stage[0]) begin
          prod <= vreg * MINV;
        end
        if (stage[1]) begin
          rem <= AB'(vreg - quot * NK);
        end
      end
    end
  endgenerate

endmodule

// ----- hdl/hermite_lattice_noise_3d_top.sv -----
// evaluate request run time, with a power-of-two table size, is set by three dependent
// single-port table reads per corner and a shared multiplier that runs nine multiplies
// per merge; other sizes spend longer on each remainder in the reciprocal remainder unit
// table write requests are written on acceptance and leave the block idle; one request at a time
// synchronous active-high reset clears control state; table contents are not cleared
module hermite_lattice_noise_3d_top #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  logic [1:0] opcode,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic signed [31:0] z_coord,
  input  logic [7:0] table_index,
  input  logic [7:0] perm_value,
  input  logic [15:0] corner_value,
  input  logic signed [15:0] tangent_x,
  input  logic signed [15:0] tangent_y,
  input  logic signed [15:0] tangent_z,
  output logic rsp_valid,
  input  logic rsp_ready,
  output logic [16:0] noise_value,
  output logic signed [15:0] grad_x,
  output logic signed [15:0] grad_y,
  output logic signed [15:0] grad_z
);

  localparam int F = FRAC_BITS;
  localparam int AB = $clog2(TABLE_SIZE);
  localparam int IXW = (AB + 1 > 8) ? AB + 1 : 9;
  localparam int BASEW = 32 - F;
  localparam int MW = ((BASEW > AB) ? BASEW : AB) + 1;
  localparam int VW = hln_pkg::VAL_W;
  localparam int TW = hln_pkg::TAN_W;
  localparam int AW = (VW > F + 1) ? VW : F + 1;
  localparam int BW = F + 2;
  localparam int PW = AW + BW;
  localparam int ACW = PW + 2;
  localparam int HW = F + 4;
  localparam int KMUL = ((1 << (BASEW - 1)) + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam logic [MW-1:0] MOD_K = MW'(KMUL * TABLE_SIZE);

  hln_pkg::state_t state, state_next;

  logic [7:0] perm_mem [TABLE_SIZE];
  logic [63:0] lat_mem [TABLE_SIZE];
  logic [7:0] pdata;
  logic [63:0] ldata;
  logic [AB-1:0] perm_raddr;

  logic signed [BASEW-1:0] base [3];
  logic [F-1:0] frac [3];
  logic [AB-1:0] bm [3];
  logic [AB-1:0] bm1 [3];
  logic [1:0] ax;
  logic [2:0] corner;
  logic [1:0] level;
  logic [3:0] mop;
  logic phase;

  logic mod_start, mod_done;
  logic [MW-1:0] mod_value;
  logic [AB-1:0] rem;

  hln_pkg::node_t na, nb, nx, ny, nm, lo, hi, lnode;
  logic [F-1:0] t_cur, t2, t3;
  logic signed [HW-1:0] t_e, t2_e, t3_e, h0_e, h1_e, h2_e, h3_e;
  logic signed [BW-1:0] h0, h1, h2, h3, t_b;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [ACW-1:0] acc, acc_sum;
  logic signed [TW:0] tdiff;
  logic signed [TW-1:0] lo_tk, hi_tk, lo_ta, hi_ta;
  logic [AB-1:0] px, py, pz;
  logic [IXW-1:0] idx_ext;
  logic idx_ok, req_acc;
  logic signed [VW-1:0] vres;

  assign req_acc = req_valid && req_ready;
  assign idx_ext = IXW'(table_index);
  assign idx_ok = idx_ext < IXW'(TABLE_SIZE);

  hln_mod #(.N(TABLE_SIZE), .MW(MW)) u_mod (
    .clk(clk),
    .rst(rst),
    .start(mod_start),
    .value(mod_value),
    .done(mod_done),
    .rem(rem)
  );

  assign px = corner[0] ? bm1[0] : bm[0];
  assign py = corner[1] ? bm1[1] : bm[1];
  assign pz = corner[2] ? bm1[2] : bm[2];

  // table storage
  always_ff @(posedge clk) begin
    if (req_acc && opcode == hln_pkg::OP_PERM && idx_ok) begin
      perm_mem[idx_ext[AB-1:0]] <= perm_value;
    end
    pdata <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk) begin
    if (req_acc && opcode == hln_pkg::OP_DATA && idx_ok) begin
      lat_mem[idx_ext[AB-1:0]] <= {corner_value, tangent_z, tangent_y, tangent_x};
    end
    ldata <= lat_mem[rem];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hln_pkg::S_IDLE: begin
        if (req_acc && opcode == hln_pkg::OP_EVAL) state_next = hln_pkg::S_AX;
      end
      hln_pkg::S_AX: state_next = hln_pkg::S_AXW;
      hln_pkg::S_AXW: begin
        if (mod_done) state_next = (ax == 2'd2) ? hln_pkg::S_RD1 : hln_pkg::S_AX;
      end
      hln_pkg::S_RD1: state_next = hln_pkg::S_MOD1;
      hln_pkg::S_MOD1: state_next = hln_pkg::S_MW1;
      hln_pkg::S_MW1: begin
        if (mod_done) state_next = hln_pkg::S_RD2;
      end
      hln_pkg::S_RD2: state_next = hln_pkg::S_MOD2;
      hln_pkg::S_MOD2: state_next = hln_pkg::S_MW2;
      hln_pkg::S_MW2: begin
        if (mod_done) state_next = hln_pkg::S_RD3;
      end
      hln_pkg::S_RD3: state_next = hln_pkg::S_LD;
      hln_pkg::S_LD: state_next = corner[0] ? hln_pkg::S_MERGE : hln_pkg::S_RD1;
      hln_pkg::S_MERGE: begin
        if (phase && mop == hln_pkg::MOP_GZ) state_next = hln_pkg::S_POST;
      end
      hln_pkg::S_POST: begin
        case (level)
          2'd0: state_next = corner[1] ? hln_pkg::S_MERGE : hln_pkg::S_RD1;
          2'd1: state_next = corner[2] ? hln_pkg::S_MERGE : hln_pkg::S_RD1;
          default: state_next = hln_pkg::S_DONE;
        endcase
      end
      hln_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = hln_pkg::S_IDLE;
      end
      default: state_next = hln_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    mod_start = 1'b0;
    mod_value = MW'(base[ax]) + MOD_K;
    perm_raddr = rem;
    case (state)
      hln_pkg::S_IDLE: req_ready = 1'b1;
      hln_pkg::S_AX: mod_start = 1'b1;
      hln_pkg::S_RD1: perm_raddr = px;
      hln_pkg::S_MOD1: begin
        mod_start = 1'b1;
        mod_value = MW'(pdata) + MW'(py);
      end
      hln_pkg::S_MOD2: begin
        mod_start = 1'b1;
        mod_value = MW'(pdata) + MW'(pz);
      end
      default: ;
    endcase
  end

  // merge operands
  always_comb begin
    case (level)
      2'd0: begin
        lo = na;
        hi = nb;
      end
      2'd1: begin
        lo = nx;
        hi = nm;
      end
      default: begin
        lo = ny;
        hi = nm;
      end
    endcase
  end

  assign t_cur = frac[level];
  assign t_e = HW'({1'b0, t_cur});
  assign t2_e = HW'({1'b0, t2});
  assign t3_e = HW'({1'b0, t3});
  assign h0_e = HW'(2) * t3_e - HW'(3) * t2_e + (HW'(1) <<< F);
  assign h1_e = HW'(3) * t2_e - HW'(2) * t3_e;
  assign h2_e = t3_e - HW'(2) * t2_e + t_e;
  assign h3_e = t3_e - t2_e;
  assign h0 = BW'(h0_e);
  assign h1 = BW'(h1_e);
  assign h2 = BW'(h2_e);
  assign h3 = BW'(h3_e);
  assign t_b = BW'({1'b0, t_cur});

  assign lo_ta = $signed(lo.tan[level]);
  assign hi_ta = $signed(hi.tan[level]);

  always_comb begin
    lo_tk = '0;
    hi_tk = '0;
    case (mop)
      hln_pkg::MOP_GX: begin
        lo_tk = $signed(lo.tan[0]);
        hi_tk = $signed(hi.tan[0]);
      end
      hln_pkg::MOP_GY: begin
        lo_tk = $signed(lo.tan[1]);
        hi_tk = $signed(hi.tan[1]);
      end
      default: begin
        lo_tk = $signed(lo.tan[2]);
        hi_tk = $signed(hi.tan[2]);
      end
    endcase
  end

  assign tdiff = (TW+1)'(hi_tk) - (TW+1)'(lo_tk);

  always_comb begin
    ma = '0;
    mb = t_b;
    case (mop)
      hln_pkg::MOP_TT: ma = AW'($signed({1'b0, t_cur}));
      hln_pkg::MOP_T2T: ma = AW'($signed({1'b0, t2}));
      hln_pkg::MOP_V0: begin
        ma = AW'(lo.val);
        mb = h0;
      end
      hln_pkg::MOP_V1: begin
        ma = AW'(hi.val);
        mb = h1;
      end
      hln_pkg::MOP_T0: begin
        ma = AW'($signed({lo_ta, 2'b00}));
        mb = h2;
      end
      hln_pkg::MOP_T1: begin
        ma = AW'($signed({hi_ta, 2'b00}));
        mb = h3;
      end
      default: ma = AW'(tdiff);
    endcase
  end

  assign acc_sum = acc + ACW'(prod);
  assign vres = VW'(acc_sum >>> F);
  assign lnode.val = VW'({1'b0, ldata[63:48]});
  assign lnode.tan = ldata[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hln_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hln_pkg::S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      hln_pkg::S_IDLE: begin
        base[0] <= x_coord[31:F];
        base[1] <= y_coord[31:F];
        base[2] <= z_coord[31:F];
        frac[0] <= x_coord[F-1:0];
        frac[1] <= y_coord[F-1:0];
        frac[2] <= z_coord[F-1:0];
        ax <= 2'd0;
        corner <= 3'd0;
        mop <= hln_pkg::MOP_TT;
        phase <= 1'b0;
      end
      hln_pkg::S_AXW: begin
        if (mod_done) begin
          bm[ax] <= rem;
          bm1[ax] <= (rem == AB'(TABLE_SIZE - 1)) ? '0 : rem + 1'b1;
          ax <= ax + 2'd1;
        end
      end
      hln_pkg::S_LD: begin
        if (corner[0]) begin
          nb <= lnode;
          level <= 2'd0;
        end else begin
          na <= lnode;
          corner <= corner + 3'd1;
        end
      end
      hln_pkg::S_MERGE: begin
        phase <= ~phase;
        if (!phase) begin
          prod <= ma * mb;
        end else begin
          mop <= (mop == hln_pkg::MOP_GZ) ? hln_pkg::MOP_TT : mop + 4'd1;
          case (mop)
            hln_pkg::MOP_TT: t2 <= prod[F +: F];
            hln_pkg::MOP_T2T: t3 <= prod[F +: F];
            hln_pkg::MOP_V0: acc <= ACW'(prod);
            hln_pkg::MOP_V1, hln_pkg::MOP_T0: acc <= acc_sum;
            hln_pkg::MOP_T1: nm.val <= vres;
            hln_pkg::MOP_GX: nm.tan[0] <= lo.tan[0] + TW'(prod >>> F);
            hln_pkg::MOP_GY: nm.tan[1] <= lo.tan[1] + TW'(prod >>> F);
            default: nm.tan[2] <= lo.tan[2] + TW'(prod >>> F);
          endcase
        end
      end
      hln_pkg::S_POST: begin
        case (level)
          2'd0: begin
            if (corner[1]) begin
              level <= 2'd1;
            end else begin
              nx <= nm;
              corner <= corner + 3'd1;
            end
          end
          2'd1: begin
            if (corner[2]) begin
              level <= 2'd2;
            end else begin
              ny <= nm;
              corner <= corner + 3'd1;
            end
          end
          default: ;
        endcase
      end
      hln_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          if (nm.val < 0) begin
            noise_value <= '0;
          end else if (nm.val > VW'(hln_pkg::NOISE_MAX)) begin
            noise_value <= hln_pkg::NOISE_W'(hln_pkg::NOISE_MAX);
          end else begin
            noise_value <= nm.val[hln_pkg::NOISE_W-1:0];
          end
          grad_x <= nm.tan[0];
          grad_y <= nm.tan[1];
          grad_z <= nm.tan[2];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/hln_chk.sv -----
module hln_chk (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic [1:0] opcode,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [16:0] noise_value,
  input logic signed [15:0] grad_x
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value) && $stable(grad_x))
    else $error("response dropped or changed while stalled");

  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> noise_value <= 17'd65536)
    else $error("noise value above one");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && opcode == hln_pkg::OP_EVAL |=> !req_ready)
    else $error("evaluate request did not hold the block busy");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && opcode != hln_pkg::OP_EVAL && !rsp_valid |=> !rsp_valid)
    else $error("response without evaluate request");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind hermite_lattice_noise_3d_top hln_chk u_hln_chk (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_ENTRIES = 256;
  localparam int FRAC = 16;

  typedef struct {
    logic [1:0] op;
    logic signed [31:0] x, y, z;
    logic [7:0] idx;
    logic [7:0] pv;
    logic [15:0] cv;
    logic signed [15:0] tx, ty, tz;
  } noise_req_t;

  typedef struct {
    logic [16:0] noise;
    logic [15:0] gx, gy, gz;
  } noise_rsp_t;

  typedef struct {
    longint val;
    longint tan[3];
  } corner_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  logic [1:0] opcode = hln_pkg::OP_EVAL;
  logic signed [31:0] x_coord = 0, y_coord = 0, z_coord = 0;
  logic [7:0] table_index = 0, perm_value = 0;
  logic [15:0] corner_value = 0;
  logic signed [15:0] tangent_x = 0, tangent_y = 0, tangent_z = 0;
  logic rsp_valid;
  logic rsp_ready = 0;
  logic [16:0] noise_value;
  logic signed [15:0] grad_x, grad_y, grad_z;

  noise_req_t pending_reqs[$];
  noise_rsp_t expected_noise[$];
  noise_req_t held_req;
  logic [7:0] perm_shadow[NUM_ENTRIES];
  corner_t lattice_shadow[NUM_ENTRIES];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int evals_done = 0;
  int writes_done = 0;
  int ignored_done = 0;
  int results_checked = 0;

  hermite_lattice_noise_3d_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .opcode(opcode), .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .table_index(table_index), .perm_value(perm_value), .corner_value(corner_value),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .noise_value(noise_value), .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic corner_t hermite_merge(corner_t a, corner_t b, int axis, longint t);
    corner_t r;
    longint t2, t3, h0, h1, h2, h3, acc;
    t2 = (t * t) >>> FRAC;
    t3 = (t2 * t) >>> FRAC;
    h0 = 2 * t3 - 3 * t2 + (longint'(1) << FRAC);
    h1 = 3 * t2 - 2 * t3;
    h2 = t3 - 2 * t2 + t;
    h3 = t3 - t2;
    acc = a.val * h0 + b.val * h1 + 4 * a.tan[axis] * h2 + 4 * b.tan[axis] * h3;
    r.val = acc >>> FRAC;
    for (int k = 0; k < 3; k++) begin
      r.tan[k] = a.tan[k] + (((b.tan[k] - a.tan[k]) * t) >>> FRAC);
    end
    return r;
  endfunction

  function automatic noise_rsp_t predict_noise(noise_req_t rq);
    noise_rsp_t r;
    corner_t c[8];
    longint base[3], frac[3], h, v;
    logic signed [31:0] p[3];
    p[0] = rq.x;
    p[1] = rq.y;
    p[2] = rq.z;
    for (int a = 0; a < 3; a++) begin
      base[a] = longint'(p[a]) >>> FRAC;
      frac[a] = longint'(p[a][FRAC-1:0]);
    end
    for (int i = 0; i < 8; i++) begin
      h = perm_shadow[(base[0] + (i & 1)) & (NUM_ENTRIES - 1)];
      h = perm_shadow[(h + base[1] + ((i >> 1) & 1)) & (NUM_ENTRIES - 1)];
      h = (h + base[2] + ((i >> 2) & 1)) & (NUM_ENTRIES - 1);
      c[i] = lattice_shadow[h];
    end
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 8; i += (2 << a)) begin
        c[i] = hermite_merge(c[i], c[i + (1 << a)], a, frac[a]);
      end
    end
    v = c[0].val;
    if (v < 0) v = 0;
    else if (v > hln_pkg::NOISE_MAX) v = hln_pkg::NOISE_MAX;
    r.noise = v[16:0];
    r.gx = c[0].tan[0][15:0];
    r.gy = c[0].tan[1][15:0];
    r.gz = c[0].tan[2][15:0];
    return r;
  endfunction

  function automatic void apply_request(noise_req_t rq);
    if (rq.op == hln_pkg::OP_PERM) begin
      perm_shadow[rq.idx] = rq.pv;
      writes_done++;
    end else if (rq.op == hln_pkg::OP_DATA) begin
      lattice_shadow[rq.idx].val = longint'(rq.cv);
      lattice_shadow[rq.idx].tan[0] = longint'(rq.tx);
      lattice_shadow[rq.idx].tan[1] = longint'(rq.ty);
      lattice_shadow[rq.idx].tan[2] = longint'(rq.tz);
      writes_done++;
    end else if (rq.op == hln_pkg::OP_EVAL) begin
      expected_noise.push_back(predict_noise(rq));
      evals_done++;
    end else begin
      ignored_done++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 0;
    end else begin
      if (req_valid && req_ready) apply_request(held_req);
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = pending_reqs.pop_front();
          opcode <= held_req.op;
          x_coord <= held_req.x;
          y_coord <= held_req.y;
          z_coord <= held_req.z;
          table_index <= held_req.idx;
          perm_value <= held_req.pv;
          corner_value <= held_req.cv;
          tangent_x <= held_req.tx;
          tangent_y <= held_req.ty;
          tangent_z <= held_req.tz;
          req_valid <= 1;
        end else begin
          req_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    noise_rsp_t e;
    if (rst) begin
      rsp_ready <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_noise.size() == 0) begin
          $error("unexpected result noise_value=%0d", noise_value);
          fail_count++;
        end else begin
          e = expected_noise.pop_front();
          results_checked++;
          if (noise_value !== e.noise) begin
            $error("noise_value expected %0d actual %0d", e.noise, noise_value);
            fail_count++;
          end
          if (grad_x !== e.gx) begin
            $error("grad_x expected %0d actual %0d", $signed(e.gx), grad_x);
            fail_count++;
          end
          if (grad_y !== e.gy) begin
            $error("grad_y expected %0d actual %0d", $signed(e.gy), grad_y);
            fail_count++;
          end
          if (grad_z !== e.gz) begin
            $error("grad_z expected %0d actual %0d", $signed(e.gz), grad_z);
            fail_count++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic noise_req_t rand_fill(logic [1:0] op);
    noise_req_t rq;
    rq.op = op;
    rq.x = $urandom;
    rq.y = $urandom;
    rq.z = $urandom;
    rq.idx = $urandom;
    rq.pv = $urandom;
    rq.cv = $urandom;
    rq.tx = $urandom;
    rq.ty = $urandom;
    rq.tz = $urandom;
    return rq;
  endfunction

  function automatic noise_req_t lattice_write(logic [7:0] idx);
    noise_req_t rq;
    int pick;
    rq = rand_fill(hln_pkg::OP_DATA);
    rq.idx = idx;
    pick = $urandom_range(9);
    if (pick == 0) rq.cv = 16'hffff;
    else if (pick == 1) rq.cv = 0;
    if ($urandom_range(3) != 0) begin
      rq.tx = $signed($urandom_range(32768)) - 16384;
      rq.ty = $signed($urandom_range(32768)) - 16384;
      rq.tz = $signed($urandom_range(32768)) - 16384;
    end
    return rq;
  endfunction

  function automatic noise_req_t eval_at(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    noise_req_t rq;
    rq = rand_fill(hln_pkg::OP_EVAL);
    rq.x = x;
    rq.y = y;
    rq.z = z;
    return rq;
  endfunction

  task automatic drain(int idle, int stall);
    while (pending_reqs.size() > 0 || req_valid || expected_noise.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    send_idle_pct = idle;
    recv_stall_pct = stall;
  endtask

  initial begin
    noise_req_t rq;
    int pick;
    repeat (7) @(posedge clk);
    rst <= 0;

    // table load, with extreme entries at both ends
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      rq = rand_fill(hln_pkg::OP_PERM);
      rq.idx = i;
      pending_reqs.push_back(rq);
    end
    for (int i = 0; i < NUM_ENTRIES; i++) pending_reqs.push_back(lattice_write(i));
    rq = rand_fill(hln_pkg::OP_DATA);
    rq.idx = 0; rq.cv = 16'hffff; rq.tx = 16'sh7fff; rq.ty = 16'sh7fff; rq.tz = 16'sh7fff;
    pending_reqs.push_back(rq);
    rq.idx = 255; rq.cv = 0; rq.tx = -16'sh8000; rq.ty = -16'sh8000; rq.tz = -16'sh8000;
    pending_reqs.push_back(rq);
    rq = rand_fill(hln_pkg::OP_PERM);
    rq.idx = 0; rq.pv = 8'hff;
    pending_reqs.push_back(rq);
    rq.idx = 255; rq.pv = 0;
    pending_reqs.push_back(rq);
    drain(0, 0);

    // directed points
    pending_reqs.push_back(eval_at(0, 0, 0));
    pending_reqs.push_back(eval_at(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_reqs.push_back(eval_at(32'h80000000, 32'h80000000, 32'h80000000));
    pending_reqs.push_back(eval_at(32'hffffffff, 32'hffffffff, 32'hffffffff));
    pending_reqs.push_back(eval_at(32'h0000ffff, 32'h00008000, 32'h00000001));
    pending_reqs.push_back(eval_at(32'h00010000, -32'sh10000, 32'h00ff8000));
    pending_reqs.push_back(eval_at(-32'sh8000, 32'h7fff0000, 32'h80000000));
    pending_reqs.push_back(rand_fill(hln_pkg::OP_RSVD));
    pending_reqs.push_back(eval_at(32'h00004000, 32'h0000c000, 32'hffff4000));
    drain(0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: drain(0, 0);
        1: drain(60, 0);
        2: drain(0, 60);
        default: drain(14, 14);
      endcase
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          rq = rand_fill(hln_pkg::OP_EVAL);
          if ($urandom_range(3) == 0) begin
            rq.x = $signed($urandom_range(262143)) - 131072;
            rq.y = $signed($urandom_range(262143)) - 131072;
            rq.z = $signed($urandom_range(262143)) - 131072;
          end
        end else if (pick < 90) begin
          rq = lattice_write($urandom);
        end else if (pick < 97) begin
          rq = rand_fill(hln_pkg::OP_PERM);
        end else begin
          rq = rand_fill(hln_pkg::OP_RSVD);
        end
        pending_reqs.push_back(rq);
      end
    end
    drain(0, 0);

    $display("covered %0d evaluate requests, %0d table writes, %0d unused-opcode requests",
             evals_done, writes_done, ignored_done);
    $display("checked %0d results across four handshake pressure phases", results_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/hln_pkg.sv
hdl/hln_mod.sv
hdl/hermite_lattice_noise_3d_top.sv
hdl/hln_chk.sv
bench/tb_top.sv
